/* rtl/tof_lrc_pkg.sv */
// ----------------------------------------------------------------------------
// tof_lrc_pkg
// Shared types, constants and register codes of the left/right coincidence
// finder: request payloads, per-counter store entry, field widths.
// ----------------------------------------------------------------------------
package tof_lrc_pkg;

  // Fixed field widths
  localparam int ENERGY_W    = 13;
  localparam int TIME_W      = 3;
  localparam int CNT_OUT_W   = 6;
  localparam int MASK_W      = 8;
  localparam int THR_W       = 16;
  localparam int THR_SQ_W    = 2 * THR_W;
  localparam int WIN_CFG_W   = 4;

  // Behavior constants
  localparam int NUM_COUNTERS_DEF = 48;
  localparam int FRAMES_PER_SLICE = 8;
  localparam int SLICE_DEPTH      = 3;
  localparam int ENERGY_BITS      = 13;
  localparam int WINDOW_RESET     = 2;

  // Saturated window register width
  localparam int WIN_W = $clog2(FRAMES_PER_SLICE + 1);

  // Energy mask after limiting to ENERGY_BITS
  localparam logic [ENERGY_W-1:0] EMASK =
    (ENERGY_BITS >= ENERGY_W) ? {ENERGY_W{1'b1}} : ENERGY_W'((1 << ENERGY_BITS) - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 2'd2;

  typedef struct packed {
    logic [ENERGY_W-1:0] strip_energy_left;
    logic [TIME_W-1:0]   strip_time_left;
    logic [ENERGY_W-1:0] strip_energy_right;
    logic [TIME_W-1:0]   strip_time_right;
    logic [ENERGY_W-1:0] pair_energy_left;
    logic [TIME_W-1:0]   pair_time_left;
    logic [ENERGY_W-1:0] pair_energy_right;
    logic [TIME_W-1:0]   pair_time_right;
  } in_item_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] counter_number;
    logic [MASK_W-1:0]    hit_mask;
    logic                 slice_done;
  } out_item_t;

  // Left side of the slice before the previous one
  typedef struct packed {
    logic [ENERGY_W-1:0] strip_energy_left;
    logic [TIME_W-1:0]   strip_time_left;
    logic [ENERGY_W-1:0] pair_energy_left;
    logic [TIME_W-1:0]   pair_time_left;
  } left_item_t;

  typedef struct packed {
    in_item_t   prev;
    left_item_t older;
  } store_entry_t;

endpackage

/* rtl/tof_lrc_ram.sv */
// ----------------------------------------------------------------------------
// tof_lrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tof_lrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tof_lrc_side.sv */
// ----------------------------------------------------------------------------
// tof_lrc_side
// One side test: a right hit against the left hits of three slices,
// giving the frame mask of matches.
// ----------------------------------------------------------------------------
module tof_lrc_side (
  input  logic [tof_lrc_pkg::ENERGY_W-1:0]                         er,
  input  logic [tof_lrc_pkg::TIME_W-1:0]                           tr,
  input  logic [tof_lrc_pkg::SLICE_DEPTH-1:0][tof_lrc_pkg::ENERGY_W-1:0] el,
  input  logic [tof_lrc_pkg::SLICE_DEPTH-1:0][tof_lrc_pkg::TIME_W-1:0]   tl,
  input  logic [tof_lrc_pkg::THR_SQ_W-1:0]                         thr_sq,
  input  logic [tof_lrc_pkg::WIN_W-1:0]                            win,
  output logic [tof_lrc_pkg::MASK_W-1:0]                           mask
);
  import tof_lrc_pkg::*;

  localparam int DW = $clog2(SLICE_DEPTH * FRAMES_PER_SLICE + (1 << TIME_W)) + 2;
  localparam int PROD_W = 2 * ENERGY_W;

  always_comb begin
    logic [PROD_W-1:0]     prod;
    logic signed [DW-1:0]  lhs;
    logic signed [DW-1:0]  rhs;
    logic signed [DW-1:0]  diff;
    logic                  hit;
    hit = 1'b0;
    for (int j = 0; j < SLICE_DEPTH; j++) begin
      prod = PROD_W'(er) * PROD_W'(el[j]);
      lhs  = DW'(tl[j]) + DW'((SLICE_DEPTH - 1 - j) * FRAMES_PER_SLICE);
      rhs  = DW'(tr) + DW'(FRAMES_PER_SLICE);
      diff = lhs - rhs;
      if (diff < 0) begin
        diff = -diff;
      end
      if ((THR_SQ_W'(prod) > thr_sq) && (int'(diff) <= int'(win))) begin
        hit = 1'b1;
      end
    end
    mask = '0;
    if (hit && (int'(tr) < FRAMES_PER_SLICE)) begin
      mask[tr] = 1'b1;
    end
  end

endmodule

/* rtl/tof_left_right_coincidence.sv */
// ----------------------------------------------------------------------------
// tof_left_right_coincidence
// Left/right coincidence finder over a ring of counters, three slices deep.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request is held in the input stage while its store
//   entry is read. Counter 0 yields no result; the last counter yields two.
// Throughput: one request per cycle while the result queue has room, set by
//   the single store read and write per counter.
// Reset: clears control state and the per-counter valid bits;
//   an entry never written reads as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module tof_left_right_coincidence #(
  parameter int NUM_COUNTERS = tof_lrc_pkg::NUM_COUNTERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [tof_lrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tof_lrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tof_lrc_pkg::in_item_t              in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tof_lrc_pkg::out_item_t             out_data
);
  import tof_lrc_pkg::*;

  localparam int PW = $clog2(NUM_COUNTERS);
  localparam logic [PW-1:0] LAST_POS = PW'(NUM_COUNTERS - 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FP_W = $clog2(FIFO_DEPTH);
  localparam int FC_W = $clog2(FIFO_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Configuration: store squared thresholds and the saturated window
  // --------------------------------------------------------------------------
  logic [THR_SQ_W-1:0] strip_sq_r;
  logic [THR_SQ_W-1:0] cluster_sq_r;
  logic [WIN_W-1:0]    win_r;
  logic [WIN_CFG_W-1:0] win_val;
  logic [WIN_W-1:0]    win_nxt;
  logic [THR_SQ_W-1:0] thr_sq_nxt;

  assign win_val = cfg_wdata[WIN_CFG_W-1:0];
  assign win_nxt = (int'(win_val) > FRAMES_PER_SLICE) ? WIN_W'(FRAMES_PER_SLICE)
                                                      : WIN_W'(win_val);
  assign thr_sq_nxt = THR_SQ_W'(cfg_wdata) * THR_SQ_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_sq_r   <= '0;
      cluster_sq_r <= '0;
      win_r        <= WIN_W'(WINDOW_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STRIP_THR:   strip_sq_r   <= thr_sq_nxt;
        CFG_CLUSTER_THR: cluster_sq_r <= thr_sq_nxt;
        CFG_WINDOW:      win_r        <= win_nxt;
        default:         ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: hold the request, issue the store read for its counter
  // --------------------------------------------------------------------------
  logic          in_acc;
  logic          s1_valid_r;
  logic          s1_adv;
  in_item_t      s1_data_r;
  logic [PW-1:0] s1_pos_r;
  logic [PW-1:0] position_r;
  logic [PW-1:0] position_nxt;
  logic          rd_valid_r;
  logic [NUM_COUNTERS-1:0] vld_r;
  logic          room;

  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign position_nxt = (position_r == LAST_POS) ? '0 : position_r + PW'(1);

  // Mask energies down to the active bit count
  function automatic in_item_t mask_item(input in_item_t d);
    in_item_t m;
    m = d;
    m.strip_energy_left  = d.strip_energy_left  & EMASK;
    m.strip_energy_right = d.strip_energy_right & EMASK;
    m.pair_energy_left   = d.pair_energy_left   & EMASK;
    m.pair_energy_right  = d.pair_energy_right  & EMASK;
    return m;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      position_r <= '0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
      position_r <= position_nxt;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload and the entry's valid flag travel with the read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r  <= mask_item(in_data);
      s1_pos_r   <= position_r;
      rd_valid_r <= vld_r[position_r];
    end
  end

  // --------------------------------------------------------------------------
  // Per-counter store: previous slice whole plus older left side
  // --------------------------------------------------------------------------
  store_entry_t rd_entry;
  store_entry_t wr_entry;
  in_item_t     mid;
  left_item_t   old;

  tof_lrc_ram #(
    .WIDTH ($bits(store_entry_t)),
    .DEPTH (NUM_COUNTERS)
  ) u_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos_r),
    .wdata (wr_entry),
    .re    (in_acc),
    .raddr (position_r),
    .rdata (rd_entry)
  );

  // An entry never written reads as zero
  assign mid = rd_valid_r ? rd_entry.prev  : '0;
  assign old = rd_valid_r ? rd_entry.older : '0;

  // Shift: newest becomes previous, previous left becomes older
  always_comb begin
    wr_entry.prev                    = s1_data_r;
    wr_entry.older.strip_energy_left = mid.strip_energy_left;
    wr_entry.older.strip_time_left   = mid.strip_time_left;
    wr_entry.older.pair_energy_left  = mid.pair_energy_left;
    wr_entry.older.pair_time_left    = mid.pair_time_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (s1_adv) begin
      vld_r[s1_pos_r] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Coincidence tests: previous right side vs. oldest, previous, newest left
  // --------------------------------------------------------------------------
  logic [MASK_W-1:0] smask;
  logic [MASK_W-1:0] cmask;

  tof_lrc_side u_strip (
    .er     (mid.strip_energy_right),
    .tr     (mid.strip_time_right),
    .el     ({old.strip_energy_left, mid.strip_energy_left, s1_data_r.strip_energy_left}),
    .tl     ({old.strip_time_left, mid.strip_time_left, s1_data_r.strip_time_left}),
    .thr_sq (strip_sq_r),
    .win    (win_r),
    .mask   (smask)
  );

  tof_lrc_side u_pair (
    .er     (mid.pair_energy_right),
    .tr     (mid.pair_time_right),
    .el     ({old.pair_energy_left, mid.pair_energy_left, s1_data_r.pair_energy_left}),
    .tl     ({old.pair_time_left, mid.pair_time_left, s1_data_r.pair_time_left}),
    .thr_sq (cluster_sq_r),
    .win    (win_r),
    .mask   (cmask)
  );

  // --------------------------------------------------------------------------
  // Hit masks: strip AND (own pair OR lower neighbour pair), ring wrap
  // --------------------------------------------------------------------------
  logic [MASK_W-1:0] lower_pair_r;
  logic [MASK_W-1:0] first_strip_r;
  logic [MASK_W-1:0] first_pair_r;
  logic              has_p;
  logic              has_0;
  out_item_t         res_p;
  out_item_t         res_0;
  out_item_t         push_a;
  logic [1:0]        n_push;

  assign has_p = (s1_pos_r != '0);
  assign has_0 = (s1_pos_r == LAST_POS);

  always_comb begin
    res_p.counter_number = CNT_OUT_W'(s1_pos_r);
    res_p.hit_mask       = smask & (cmask | lower_pair_r);
    res_p.slice_done     = 1'b0;
    res_0.counter_number = '0;
    res_0.hit_mask       = first_strip_r & (first_pair_r | cmask);
    res_0.slice_done     = 1'b1;
    push_a = has_p ? res_p : res_0;
    n_push = s1_adv ? (2'(has_p) + 2'(has_0)) : 2'd0;
  end

  // Keep the lower neighbour's pair mask; hold counter 0 masks until the ring closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_pair_r  <= '0;
      first_strip_r <= '0;
      first_pair_r  <= '0;
    end else if (s1_adv) begin
      lower_pair_r <= cmask;
      if (!has_p) begin
        first_strip_r <= smask;
        first_pair_r  <= cmask;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: absorbs the double result of the last counter
  // --------------------------------------------------------------------------
  out_item_t       fifo_r [FIFO_DEPTH];
  logic [FP_W-1:0] head_r;
  logic [FP_W-1:0] tail_r;
  logic [FC_W-1:0] count_r;
  logic [FC_W-1:0] count_nxt;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_data  = fifo_r[head_r];
  assign pop       = out_valid && !out_stall;

  // Advance only with space for two results after this cycle's pop
  assign room   = (int'(count_r) - int'(pop)) <= (FIFO_DEPTH - 2);
  assign s1_adv = s1_valid_r && room;

  assign count_nxt = count_r - FC_W'(pop) + FC_W'(n_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (pop) begin
        head_r <= head_r + FP_W'(1);
      end
      tail_r  <= tail_r + FP_W'(n_push);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[tail_r] <= push_a;
    end
    if (n_push == 2'd2) begin
      fifo_r[tail_r + FP_W'(1)] <= res_0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= FIFO_DEPTH)
    else $error("result queue overflow");

  a_done_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slice_done |-> out_data.counter_number == '0)
    else $error("slice_done on a counter other than zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!s1_valid_r || s1_adv))
    else $error("input stage overwritten while held");

  a_ring_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (position_r == LAST_POS) |=> position_r == '0)
    else $error("position did not wrap after last counter");

  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s1_adv |-> s1_pos_r != position_r)
    else $error("store read and write on the same counter");

endmodule
